>>> sv/rbt_pkg.sv
package rbt_pkg;

	localparam int CFG_W = 7;

	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic REG_BUFFER_LEN     = 1'b0;
	localparam logic REG_FILL_THRESHOLD = 1'b1;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_THRES = 2'd1;
	localparam logic [1:0] EV_OVER  = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic [6:0] read_count;
	} in_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] data_byte;
		logic       last;
		logic       underflow;
	} out_t;

endpackage

>>> sv/rbt_ram.sv
module rbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/rx_ring_buffer_threshold_top.sv
// Receive ring buffer with a fill threshold.
//
// Input: a word on item is taken at a rising edge with start high and busy low.
// A received-byte word (cmd 0) is stored at the write index in the same edge;
// its single result (event: none, threshold or overflow) shows on result,
// marked by result_stb, in the next cycle. Received bytes can be taken every
// cycle, busy stays low.
// A read word (cmd 1) with read_count N (saturated to DEPTH) raises busy for
// the N reads, one RAM read per cycle at the read index; the results follow
// in the cycle after the reads, one per cycle, last on the final one; a zero
// count gives no result.
// Each result is valid for one cycle only; the receiver cannot stall it.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 buffer
// length, 1 fill threshold) at once; write only while idle.
// Reset: indices and fill clear, length 64, threshold 32; the store reads as
// zero until an entry is written (one valid flop per entry, no clearing pass).
module rx_ring_buffer_threshold_top
	import rbt_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              item,
	output logic             result_stb,
	output out_t             result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  buf_len_q;
	logic [CFG_W-1:0]  thr_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  rem_q;
	logic              uf_q;
	logic [DEPTH-1:0]  vld_q;

	logic              out_v_s1;
	logic              rd_s1;
	logic              hit_s1;
	logic [1:0]        ev_s1;
	logic              last_s1;
	logic              uf_s1;

	logic [CNT_W-1:0]  len_eff;
	logic [CNT_W-1:0]  wr_inc;
	logic [CNT_W-1:0]  rd_inc;
	logic [IDX_W-1:0]  wr_next;
	logic [IDX_W-1:0]  rd_next;
	logic [CNT_W-1:0]  fill_inc;
	logic              overflow;
	logic              thres_hit;
	logic [CNT_W-1:0]  rd_cnt;
	logic              rd_uf;
	logic              accept;
	logic              ram_we;
	logic              ram_re;
	logic [7:0]        ram_rdata;

	always_comb begin
		if (buf_len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (buf_len_q > CFG_W'(DEPTH)) begin
			len_eff = CNT_W'(DEPTH);
		end else begin
			len_eff = buf_len_q[CNT_W-1:0];
		end
	end

	assign wr_inc  = CNT_W'(wr_idx_q) + CNT_W'(1);
	assign rd_inc  = CNT_W'(rd_idx_q) + CNT_W'(1);
	assign wr_next = (wr_inc >= len_eff) ? '0 : wr_inc[IDX_W-1:0];
	assign rd_next = (rd_inc >= len_eff) ? '0 : rd_inc[IDX_W-1:0];

	assign fill_inc  = fill_q + CNT_W'(1);
	assign overflow  = (fill_inc >= len_eff);
	assign thres_hit = (CFG_W'(fill_inc) >= thr_q);

	assign rd_cnt = (item.read_count > CFG_W'(DEPTH)) ? CNT_W'(DEPTH)
		: item.read_count[CNT_W-1:0];
	assign rd_uf  = (rd_cnt > fill_q);

	assign busy   = (state_q == ST_READ);
	assign accept = start && !busy;
	assign ram_we = accept && (item.cmd == CMD_RX);
	assign ram_re = (state_q == ST_READ);

	rbt_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (item.rx_byte),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			buf_len_q <= CFG_W'(64);
			thr_q     <= CFG_W'(32);
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			fill_q    <= '0;
			rem_q     <= '0;
			uf_q      <= 1'b0;
			vld_q     <= '0;
			out_v_s1  <= 1'b0;
			rd_s1     <= 1'b0;
			hit_s1    <= 1'b0;
			ev_s1     <= EV_NONE;
			last_s1   <= 1'b0;
			uf_s1     <= 1'b0;
		end else begin
			out_v_s1 <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BUFFER_LEN:     buf_len_q <= cfg_data;
					REG_FILL_THRESHOLD: thr_q     <= cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.cmd == CMD_RX) begin
							vld_q[wr_idx_q] <= 1'b1;
							out_v_s1 <= 1'b1;
							rd_s1    <= 1'b0;
							last_s1  <= 1'b1;
							uf_s1    <= 1'b0;
							if (overflow) begin
								wr_idx_q <= '0;
								rd_idx_q <= '0;
								fill_q   <= '0;
								ev_s1    <= EV_OVER;
							end else begin
								wr_idx_q <= wr_next;
								fill_q   <= fill_inc;
								ev_s1    <= thres_hit ? EV_THRES : EV_NONE;
							end
						end else if (rd_cnt != '0) begin
							rem_q   <= rd_cnt;
							uf_q    <= rd_uf;
							fill_q  <= rd_uf ? '0 : (fill_q - rd_cnt);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					out_v_s1 <= 1'b1;
					rd_s1    <= 1'b1;
					hit_s1   <= vld_q[rd_idx_q];
					ev_s1    <= EV_NONE;
					last_s1  <= (rem_q == CNT_W'(1));
					uf_s1    <= uf_q;
					rd_idx_q <= rd_next;
					rem_q    <= rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign result_stb       = out_v_s1;
	assign result.event_res = ev_s1;
	assign result.data_byte = (rd_s1 && hit_s1) ? ram_rdata : 8'd0;
	assign result.last      = last_s1;
	assign result.underflow = uf_s1;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(DEPTH))
		else $error("fill count reached the store depth");

	a_rx_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == CMD_RX) |=> (result_stb && result.last))
		else $error("received byte gave no final result");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && rem_q == CNT_W'(1)) |=> (result_stb && result.last && !busy))
		else $error("read burst did not end with last");

	a_read_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rem_q != '0))
		else $error("read burst running with zero remaining");

endmodule

>>> tb/sv/tb_rx_ring_buffer_threshold_top.sv
module tb_rx_ring_buffer_threshold_top
	import rbt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int PLAN_ROWS = 27;

	typedef struct packed {
		logic             is_cfg;
		logic             reg_idx;
		logic [CFG_W-1:0] reg_val;
		in_t              word;
		logic             has_want;
		out_t             want;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_t              item;
	logic             result_stb;
	out_t             result;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [7:0]       ring_store [DEPTH];
	int unsigned      ring_wr;
	int unsigned      ring_rd;
	int unsigned      ring_fill;
	logic [CFG_W-1:0] ring_len;
	logic [CFG_W-1:0] ring_thr;
	out_t             due_words [$];
	logic             failed;

	rx_ring_buffer_threshold_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.result_stb(result_stb),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned ring_next(int unsigned idx, int unsigned len);
		return (idx + 1 >= len) ? 0 : idx + 1;
	endfunction

	function automatic void ring_predict(in_t w);
		int unsigned len;
		int unsigned cnt;
		int unsigned k;
		logic uf;
		out_t r;
		len = ring_len;
		if (len == 0)
			len = 1;
		if (len > DEPTH)
			len = DEPTH;
		r = '0;
		if (w.cmd == CMD_RX) begin
			ring_store[ring_wr] = w.rx_byte;
			ring_wr = ring_next(ring_wr, len);
			ring_fill = ring_fill + 1;
			r.last = 1'b1;
			if (ring_fill >= len) begin
				ring_wr = 0;
				ring_rd = 0;
				ring_fill = 0;
				r.event_res = EV_OVER;
			end else if (ring_fill >= ring_thr) begin
				r.event_res = EV_THRES;
			end else begin
				r.event_res = EV_NONE;
			end
			due_words.push_back(r);
		end else begin
			cnt = w.read_count;
			if (cnt > DEPTH)
				cnt = DEPTH;
			uf = (cnt > ring_fill);
			for (k = 0; k < cnt; k++) begin
				r.event_res = EV_NONE;
				r.data_byte = ring_store[ring_rd];
				r.last = (k + 1 == cnt);
				r.underflow = uf;
				due_words.push_back(r);
				ring_rd = ring_next(ring_rd, len);
			end
			ring_fill = uf ? 0 : ring_fill - cnt;
		end
	endfunction

	function automatic plan_row_t word_row(logic c, logic [7:0] b, logic [6:0] n,
			logic chk, out_t w);
		plan_row_t row;
		row = '0;
		row.word.cmd = c;
		row.word.rx_byte = b;
		row.word.read_count = n;
		row.has_want = chk;
		row.want = w;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(logic idx, logic [CFG_W-1:0] v);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = v;
		return row;
	endfunction

	task automatic send_word(in_t w, logic chk, out_t want);
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		ring_predict(w);
		if (chk)
			due_words[due_words.size() - 1] = want;
	endtask

	task automatic idle_some();
		if ($urandom_range(99) < 29) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 29);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == REG_BUFFER_LEN)
			ring_len = v;
		else
			ring_thr = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_t want;
		if (result_stb) begin
			if (due_words.size() == 0) begin
				$error("result word with nothing pending: %h", result);
				failed = 1'b1;
			end else begin
				want = due_words.pop_front();
				if (result.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, result.event_res);
					failed = 1'b1;
				end
				if (result.data_byte !== want.data_byte) begin
					$error("data_byte: expected %0d, got %0d", want.data_byte, result.data_byte);
					failed = 1'b1;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					failed = 1'b1;
				end
				if (result.underflow !== want.underflow) begin
					$error("underflow: expected %0d, got %0d", want.underflow,
						result.underflow);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		plan_row_t plan [PLAN_ROWS];
		logic [CFG_W-1:0] phase_len [8];
		logic [CFG_W-1:0] phase_thr [8];
		in_t w;
		int ph;
		int i;
		int pick;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BUFFER_LEN;
		cfg_data = '0;
		failed = 1'b0;
		for (i = 0; i < DEPTH; i++)
			ring_store[i] = 8'h00;
		ring_wr = 0;
		ring_rd = 0;
		ring_fill = 0;
		ring_len = 7'd64;
		ring_thr = 7'd32;

		plan[0]  = word_row(CMD_READ, 8'h00, 7'd1, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b1});
		plan[1]  = word_row(CMD_READ, 8'h00, 7'd0, 1'b0, '0);
		plan[2]  = word_row(CMD_READ, 8'hFF, 7'd127, 1'b0, '0);
		plan[3]  = word_row(CMD_RX, 8'hFF, 7'd127, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b0});
		plan[4]  = word_row(CMD_RX, 8'h00, 7'd0, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b0});
		plan[5]  = word_row(CMD_RX, 8'hA5, 7'd0, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b0});
		plan[6]  = word_row(CMD_RX, 8'h5A, 7'd0, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b0});
		plan[7]  = word_row(CMD_READ, 8'h00, 7'd2, 1'b0, '0);
		plan[8]  = word_row(CMD_READ, 8'h00, 7'd64, 1'b0, '0);
		plan[9]  = cfg_row(REG_BUFFER_LEN, 7'd2);
		plan[10] = cfg_row(REG_FILL_THRESHOLD, 7'd1);
		plan[11] = word_row(CMD_RX, 8'h3C, 7'd0, 1'b1, {EV_THRES, 8'h00, 1'b1, 1'b0});
		plan[12] = word_row(CMD_RX, 8'hC3, 7'd0, 1'b1, {EV_OVER, 8'h00, 1'b1, 1'b0});
		plan[13] = cfg_row(REG_FILL_THRESHOLD, 7'd0);
		plan[14] = word_row(CMD_RX, 8'h81, 7'd0, 1'b1, {EV_THRES, 8'h00, 1'b1, 1'b0});
		plan[15] = word_row(CMD_READ, 8'h00, 7'd1, 1'b0, '0);
		plan[16] = cfg_row(REG_BUFFER_LEN, 7'd1);
		plan[17] = word_row(CMD_RX, 8'h7E, 7'd0, 1'b1, {EV_OVER, 8'h00, 1'b1, 1'b0});
		plan[18] = cfg_row(REG_BUFFER_LEN, 7'd0);
		plan[19] = word_row(CMD_RX, 8'h42, 7'd0, 1'b1, {EV_OVER, 8'h00, 1'b1, 1'b0});
		plan[20] = cfg_row(REG_BUFFER_LEN, 7'd127);
		plan[21] = cfg_row(REG_FILL_THRESHOLD, 7'd127);
		plan[22] = word_row(CMD_RX, 8'h11, 7'd0, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b0});
		plan[23] = word_row(CMD_RX, 8'h22, 7'd0, 1'b1, {EV_NONE, 8'h00, 1'b1, 1'b0});
		plan[24] = word_row(CMD_READ, 8'h00, 7'd3, 1'b0, '0);
		plan[25] = cfg_row(REG_BUFFER_LEN, 7'd64);
		plan[26] = cfg_row(REG_FILL_THRESHOLD, 7'd64);

		phase_len = '{7'd1, 7'd64, 7'd5, 7'd16, 7'd0, 7'd127, 7'd33, 7'd0};
		phase_thr = '{7'd0, 7'd64, 7'd3, 7'd12, 7'd127, 7'd0, 7'd20, 7'd0};
		phase_len[7] = CFG_W'($urandom_range(127));
		phase_thr[7] = CFG_W'($urandom_range(127));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].is_cfg) begin
				wait_drained();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_word(plan[i].word, plan[i].has_want, plan[i].want);
				idle_some();
			end
		end

		for (ph = 0; ph < 8; ph++) begin
			wait_drained();
			write_reg(REG_BUFFER_LEN, phase_len[ph]);
			write_reg(REG_FILL_THRESHOLD, phase_thr[ph]);
			for (i = 0; i < 25; i++) begin
				if (ph == 5 && i == 14)
					wait_drained();
				w.rx_byte = 8'($urandom_range(255));
				w.read_count = 7'($urandom_range(127));
				pick = $urandom_range(99);
				if (pick < 55) begin
					w.cmd = CMD_RX;
				end else if (pick < 88) begin
					w.cmd = CMD_READ;
					w.read_count = 7'($urandom_range(1, ring_fill + 1));
				end else begin
					w.cmd = CMD_READ;
				end
				send_word(w, 1'b0, '0);
				if (ph != 3)
					idle_some();
			end
		end

		wait_drained();
		if (!failed)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> rx_ring_buffer_threshold_top.f
sv/rbt_pkg.sv
sv/rbt_ram.sv
sv/rx_ring_buffer_threshold_top.sv
tb/sv/tb_rx_ring_buffer_threshold_top.sv
